[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request and status
// codes, the classified operation passed from front to back, back FSM states.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_REM_FRONT  = 3'd2;
    localparam logic [2:0] REQ_REM_BACK   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_FULL       = 2'd1;
    localparam logic [1:0] STAT_EMPTY_REM  = 2'd2;
    localparam logic [1:0] STAT_EMPTY_LIST = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_REM_FRONT,
        OP_REM_BACK,
        OP_LIST
    } op_code_t;

    typedef struct packed {
        op_code_t                   code;
        logic signed [DATA_W-1:0]   data;
    } op_t;

    typedef enum logic [1:0] {
        S_EXEC,
        S_LREAD,
        S_LOUT
    } back_state_t;

endpackage

[rtl/deq_req_if.sv]
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          req_type;
    logic signed [deq_pkg::DATA_W-1:0]   data_value;

    modport source (output valid, output req_type, output data_value, input ready);
    modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

[rtl/deq_rsp_if.sv]
// ----------------------------------------------------------------------------
// deq_rsp_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::DATA_W-1:0]   result_value;
    logic [1:0]                          status;
    logic                                is_listing;
    logic                                last;

    modport source (output valid, output result_value, output status,
                    output is_listing, output last, input ready);
    modport sink   (input valid, input result_value, input status,
                    input is_listing, input last, output ready);
endinterface

[rtl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/deq_front.sv]
// ----------------------------------------------------------------------------
// deq_front
// Accepts request beats, decodes the request type, drops unknown types and
// buffers decoded operations in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module deq_front (
    input  logic            clk,
    input  logic            rst_n,
    deq_req_if.sink         req,
    output logic            op_valid,
    output deq_pkg::op_t    op,
    input  logic            op_ready
);

    deq_pkg::op_t       op_q_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;
    logic               known;
    deq_pkg::op_code_t  code;
    logic               push;
    logic               pop;

    always_comb
    begin
        known = 1'b1;
        code  = deq_pkg::OP_LIST;
        unique case (req.req_type)
            deq_pkg::REQ_PUSH_FRONT: code = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::REQ_PUSH_BACK:  code = deq_pkg::OP_PUSH_BACK;
            deq_pkg::REQ_REM_FRONT:  code = deq_pkg::OP_REM_FRONT;
            deq_pkg::REQ_REM_BACK:   code = deq_pkg::OP_REM_BACK;
            deq_pkg::REQ_LIST:       code = deq_pkg::OP_LIST;
            default:                 known = 1'b0;
        endcase
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready && known;
    assign op_valid  = (fill_reg != 2'd0);
    assign op        = op_q_reg[rd_ptr_reg];
    assign pop       = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg] <= '{code: code, data: req.data_value};
        end
    end

endmodule

[rtl/deq_back.sv]
// ----------------------------------------------------------------------------
// deq_back
// Executes queued operations on the ring: keeps front index and entry count,
// writes pushes into the element RAM, walks the ring for listings and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  deq_pkg::op_t    op,
    output logic            op_ready,
    deq_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    deq_pkg::back_state_t             state_reg, state_next;
    logic [IDX_W-1:0]                 front_reg, front_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                 lptr_reg, lptr_next;
    logic [CNT_W-1:0]                 lleft_reg, lleft_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [deq_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic [1:0]                       out_status_reg, out_status_next;
    logic                             out_listing_reg, out_listing_next;
    logic                             out_last_reg, out_last_next;

    logic                             slot_free;
    logic                             full;
    logic                             empty;
    logic [IDX_W-1:0]                 front_dec;
    logic [IDX_W-1:0]                 front_inc;
    logic [IDX_W-1:0]                 lptr_inc;
    logic [SUM_W-1:0]                 back_sum;
    logic [IDX_W-1:0]                 back_addr;

    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    logic                             ram_re;
    logic [deq_pkg::DATA_W-1:0]       ram_rdata;

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (op.data),
        .re    (ram_re),
        .raddr (lptr_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign lptr_inc  = (lptr_reg == IDX_W'(DEPTH - 1)) ? '0 : lptr_reg + 1'b1;
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_addr = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                   : back_sum[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        lptr_next        = lptr_reg;
        lleft_next       = lleft_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        out_listing_next = out_listing_reg;
        out_last_next    = out_last_reg;
        op_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = back_addr;
        ram_re           = 1'b0;

        unique case (state_reg)
            deq_pkg::S_EXEC:
            begin
                op_ready = slot_free;
                if (op_valid && slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = '0;
                    out_status_next  = deq_pkg::STAT_OK;
                    out_listing_next = 1'b0;
                    out_last_next    = 1'b1;
                    unique case (op.code)
                        deq_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_REM_FRONT:
                        begin
                            if (empty)
                            begin
                                out_status_next = deq_pkg::STAT_EMPTY_REM;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_REM_BACK:
                        begin
                            if (empty)
                            begin
                                out_status_next = deq_pkg::STAT_EMPTY_REM;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_LIST:
                        begin
                            if (empty)
                            begin
                                out_status_next = deq_pkg::STAT_EMPTY_LIST;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !rsp.ready;
                                lptr_next      = front_reg;
                                lleft_next     = count_reg;
                                state_next     = deq_pkg::S_LREAD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                        end
                    endcase
                end
            end
            deq_pkg::S_LREAD:
            begin
                ram_re     = 1'b1;
                lptr_next  = lptr_inc;
                state_next = deq_pkg::S_LOUT;
            end
            deq_pkg::S_LOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = ram_rdata;
                    out_status_next  = deq_pkg::STAT_OK;
                    out_listing_next = 1'b1;
                    out_last_next    = (lleft_reg == CNT_W'(1));
                    lleft_next       = lleft_reg - 1'b1;
                    state_next       = (lleft_reg == CNT_W'(1)) ? deq_pkg::S_EXEC
                                                                 : deq_pkg::S_LREAD;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_EXEC;
            front_reg     <= '0;
            count_reg     <= '0;
            lptr_reg      <= '0;
            lleft_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            lptr_reg      <= lptr_next;
            lleft_reg     <= lleft_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        out_listing_reg <= out_listing_next;
        out_last_reg    <= out_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.is_listing   = out_listing_reg;
    assign rsp.last         = out_last_reg;

endmodule

[rtl/double_ended_queue.sv]
// Results: a push or removal request is held in the front-end queue, and its
// result is registered in the back end once the result slot is free.
// Throughput: push and removal 1 request per cycle while results are taken and no
// listing runs; a listing reads, then outputs, each entry (registered RAM read).
// Reset: queue empty (front index and count zero); the element RAM is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded ring-buffer deque of signed 32-bit values with push/remove at both
// ends and a front-to-back listing.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    logic           op_valid;
    logic           op_ready;
    deq_pkg::op_t   op;

    deq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready),
        .rsp      (rsp)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue. A behavioral ring deque tracks
// every accepted request and queues the result beats it must produce. Each
// result beat is checked against the oldest queued beat. Directed tests cover
// the empty and full corners, ignored request codes and a full listing. Then
// random traffic with drifting push/remove bias runs under three idling
// profiles on the request and result channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic signed [deq_pkg::DATA_W-1:0] value;
        logic [1:0]                        status;
        logic                              listing;
        logic                              last;
    } rsp_beat_t;

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [deq_pkg::DATA_W-1:0] deque_store [DEPTH];
    int                                head_pos;
    int                                fill_count;
    rsp_beat_t                         pending_beats [$];

    int src_idle_pct;
    int snk_idle_pct;
    int err_count;
    int beats_checked;
    int n_push;
    int n_remove;
    int n_list;
    int n_ignored;
    int stall_cycles;

    always #2 clk = ~clk;

    function automatic void queue_beat(input logic signed [deq_pkg::DATA_W-1:0] value,
                                       input logic [1:0] status,
                                       input logic listing, input logic last);
        rsp_beat_t b;
        b.value   = value;
        b.status  = status;
        b.listing = listing;
        b.last    = last;
        pending_beats.push_back(b);
    endfunction

    function automatic void predict_request(input logic [2:0] kind,
                                            input logic signed [deq_pkg::DATA_W-1:0] val);
        int k;
        case (kind)
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK:
            begin
                n_push++;
                if (fill_count >= DEPTH)
                begin
                    queue_beat('0, deq_pkg::STAT_FULL, 1'b0, 1'b1);
                end
                else
                begin
                    if (kind == deq_pkg::REQ_PUSH_FRONT)
                    begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        deque_store[head_pos] = val;
                    end
                    else
                    begin
                        deque_store[(head_pos + fill_count) % DEPTH] = val;
                    end
                    fill_count++;
                    queue_beat('0, deq_pkg::STAT_OK, 1'b0, 1'b1);
                end
            end
            deq_pkg::REQ_REM_FRONT, deq_pkg::REQ_REM_BACK:
            begin
                n_remove++;
                if (fill_count == 0)
                begin
                    queue_beat('0, deq_pkg::STAT_EMPTY_REM, 1'b0, 1'b1);
                end
                else
                begin
                    if (kind == deq_pkg::REQ_REM_FRONT)
                        head_pos = (head_pos + 1) % DEPTH;
                    fill_count--;
                    queue_beat('0, deq_pkg::STAT_OK, 1'b0, 1'b1);
                end
            end
            deq_pkg::REQ_LIST:
            begin
                n_list++;
                if (fill_count == 0)
                begin
                    queue_beat('0, deq_pkg::STAT_EMPTY_LIST, 1'b0, 1'b1);
                end
                else
                begin
                    for (k = 0; k < fill_count; k++)
                        queue_beat(deque_store[(head_pos + k) % DEPTH], deq_pkg::STAT_OK,
                                   1'b1, (k + 1 == fill_count));
                end
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endfunction

    task automatic send_req(input logic [2:0] kind,
                            input logic signed [deq_pkg::DATA_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.data_value <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(kind, val);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_and_ignored();
        send_req(deq_pkg::REQ_LIST, 32'sd0);
        send_req(deq_pkg::REQ_REM_FRONT, $urandom);
        send_req(deq_pkg::REQ_REM_BACK, $urandom);
        send_req(3'd5, $urandom);
        send_req(3'd6, $urandom);
        send_req(3'd7, $urandom);
        wait_for_drain();
    endtask

    task automatic test_fill_overflow_list();
        int i;
        logic signed [deq_pkg::DATA_W-1:0] val;
        for (i = 0; i < DEPTH; i++)
        begin
            case (i % 6)
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = 32'sh0000_0000;
                3: val = -32'sd1;
                4: val = 32'sh5555_5555;
                default: val = 32'shaaaa_aaaa;
            endcase
            send_req((i % 2) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT, val);
        end
        send_req(deq_pkg::REQ_PUSH_FRONT, $urandom);
        send_req(deq_pkg::REQ_PUSH_BACK, $urandom);
        send_req(deq_pkg::REQ_LIST, $urandom);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        int          sent;
        int          push_bias;
        int unsigned pick;
        logic [2:0]  kind;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent         = 0;
        push_bias    = 50;
        while (sent < n_items)
        begin
            if ($urandom_range(19) == 0)
                push_bias = $urandom_range(85, 15);
            pick = $urandom_range(99);
            if (pick < 3)
                kind = 3'($urandom_range(7, 5));
            else if (pick < 12)
                kind = deq_pkg::REQ_LIST;
            else if ($urandom_range(99) < push_bias)
                kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
            else
                kind = $urandom_range(1) ? deq_pkg::REQ_REM_BACK : deq_pkg::REQ_REM_FRONT;
            send_req(kind, $urandom);
            if (kind <= deq_pkg::REQ_LIST)
                sent++;
        end
        wait_for_drain();
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        rsp_beat_t exp_beat;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result beat value %0d status %0d", $time,
                         rsp_ch.result_value, rsp_ch.status);
            end
            else
            begin
                exp_beat = pending_beats.pop_front();
                beats_checked++;
                if (rsp_ch.result_value !== exp_beat.value)
                begin
                    err_count++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             exp_beat.value, rsp_ch.result_value);
                end
                if (rsp_ch.status !== exp_beat.status)
                begin
                    err_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_beat.status, rsp_ch.status);
                end
                if (rsp_ch.is_listing !== exp_beat.listing)
                begin
                    err_count++;
                    $display("%0t: is_listing expected %0d actual %0d", $time,
                             exp_beat.listing, rsp_ch.is_listing);
                end
                if (rsp_ch.last !== exp_beat.last)
                begin
                    err_count++;
                    $display("%0t: last expected %0d actual %0d", $time,
                             exp_beat.last, rsp_ch.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                     STALL_LIMIT, pending_beats.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = deq_pkg::REQ_PUSH_FRONT;
        req_ch.data_value = '0;
        rsp_ch.ready      = 1'b0;
        head_pos          = 0;
        fill_count        = 0;
        src_idle_pct      = 35;
        snk_idle_pct      = 60;
        err_count         = 0;
        beats_checked     = 0;
        n_push            = 0;
        n_remove          = 0;
        n_list            = 0;
        n_ignored         = 0;
        stall_cycles      = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_ignored();
        test_fill_overflow_list();
        test_random_traffic(85, 35, 60);
        test_random_traffic(85, 60, 35);
        test_random_traffic(80, 0, 0);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d pushes, %0d removals, %0d listings, %0d ignored codes sent",
                 n_push, n_remove, n_list, n_ignored);
        $display("tb: %0d result beats checked, %0d mismatches", beats_checked, err_count);
        if (err_count == 0 && pending_beats.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
